>>> hdl/tsc_pkg.sv
// Shared types, constants and the CRC-8 step for the scratchpad checker.
`timescale 1ns / 1ps

package tsc_pkg;

    // Frame length in bytes, stored CRC byte included
    localparam int FRAME_BYTES_DEF = 9;

    // Byte counter width, enough for frames of up to 16 bytes
    localparam int CNT_W = 4;

    // Dallas/Maxim CRC-8, reflected form
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Limit reset values in sixteenths of a degree (80 and -60 degrees)
    localparam logic signed [15:0] UPPER_RESET = 16'sd1280;
    localparam logic signed [15:0] LOWER_RESET = -16'sd960;

    // Register byte addresses
    localparam logic [2:0] ADDR_UPPER = 3'd0;
    localparam logic [2:0] ADDR_LOWER = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CRC   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // One processed item as seen by the output register
    typedef struct packed {
        logic               has;
        logic [1:0]         status;
        logic signed [15:0] temperature;
        logic [7:0]         crc;
    } t_result;

    // One byte of CRC-8 update, bit by bit, LSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/temp_scratchpad_checker.sv
// Top level: input register, frame tracker, result register and config port.
`timescale 1ns / 1ps

// Scratchpad frame checker. Takes one frame byte per item on the s_axis side
// (tuser high marks byte 0) and sustains one item per clock. Each byte is held
// in an input register, then the CRC-8 update, the temperature latch and the
// limit compare work on the held byte, and a result is registered in the result
// register, which drives m_axis. Only the last byte of a frame (the stored CRC)
// gives a result; other bytes give none. The rate is limited only by output
// backpressure. The user must write limits over the APB port only while no
// frame is in flight; the block itself does not enforce this.
module temp_scratchpad_checker
    import tsc_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
    input  logic [0:0]  s_axis_tuser,   // [0] frame_start
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [1:0] status, [17:2] temperature,
                                        // [25:18] computed_crc, [31:26] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_start;
    logic               r_out_valid;
    t_result            r_out;
    t_result            res;
    logic               advance;
    logic signed [15:0] upper;
    logic signed [15:0] lower;

    tsc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_upper (upper),
        .o_lower (lower)
    );

    tsc_frame #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .i_start  (r_in_start),
        .i_upper  (upper),
        .i_lower  (lower),
        .o_result (res)
    );

    // held item moves on unless it has a result and the output is stalled
    assign advance       = r_in_valid && (!res.has || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser[0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res.has) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.has) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.crc, r_out.temperature, r_out.status};

    a_ready_only_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && res.has && r_out_valid && !m_axis_tready))
        else $error("input stalled without a blocked result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.status == ST_OK || r_out.status == ST_CRC ||
                         r_out.status == ST_RANGE))
        else $error("bad status code");

    a_held_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held item lost");

endmodule

>>> hdl/tsc_regs.sv
// Configuration registers for the temperature limits behind an APB-style port.
`timescale 1ns / 1ps

module tsc_regs
    import tsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic signed [15:0] o_upper,
    output logic signed [15:0] o_lower
);

    logic               sel_upper;
    logic signed [15:0] r_upper_limit;
    logic signed [15:0] r_lower_limit;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    // only bit 2 selects the register, byte offsets are ignored
    assign sel_upper = (paddr[2] == ADDR_UPPER[2]);

    // limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_limit <= UPPER_RESET;
            r_lower_limit <= LOWER_RESET;
        end else if (wr_en) begin
            if (sel_upper) begin
                r_upper_limit <= pwdata[15:0];
            end else begin
                r_lower_limit <= pwdata[15:0];
            end
        end
    end

    // read back, zero extended
    always_comb begin
        if (paddr[2] == ADDR_LOWER[2]) begin
            prdata = {16'd0, r_lower_limit};
        end else begin
            prdata = {16'd0, r_upper_limit};
        end
    end

    assign o_upper = r_upper_limit;
    assign o_lower = r_lower_limit;

endmodule

>>> hdl/tsc_frame.sv
// Frame tracker: byte count, running CRC, temperature latch and the final check.
`timescale 1ns / 1ps

module tsc_frame
    import tsc_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  logic               i_start,
    input  logic signed [15:0] i_upper,
    input  logic signed [15:0] i_lower,
    output t_result            o_result
);

    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);

    logic [CNT_W-1:0]   r_count;
    logic [7:0]         r_crc;
    logic [7:0]         r_temp_lo;
    logic [7:0]         r_temp_hi;
    logic [CNT_W-1:0]   idx;
    logic [7:0]         crc_cur;
    logic               is_last;
    logic signed [15:0] temp;

    // a start byte sees a cleared count and CRC
    assign idx     = i_start ? '0 : r_count;
    assign crc_cur = i_start ? 8'd0 : r_crc;
    assign is_last = (idx >= LAST_IDX);
    assign temp    = {r_temp_hi, r_temp_lo};

    // result of the current byte
    always_comb begin
        o_result.has         = is_last;
        o_result.temperature = temp;
        o_result.crc         = crc_cur;
        if (crc_cur != i_byte || crc_cur == 8'd0) begin
            o_result.status = ST_CRC;
        end else if (temp > i_upper || temp < i_lower) begin
            o_result.status = ST_RANGE;
        end else begin
            o_result.status = ST_OK;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= 8'd0;
        end else if (i_step) begin
            if (is_last) begin
                r_count <= '0;
                r_crc   <= 8'd0;
            end else begin
                r_count <= idx + 1'b1;
                r_crc   <= crc8_step(crc_cur, i_byte);
            end
        end
    end

    // temperature bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_lo <= 8'd0;
            r_temp_hi <= 8'd0;
        end else if (i_step && !is_last) begin
            if (idx == '0) begin
                r_temp_lo <= i_byte;
            end else if (idx == CNT_W'(1)) begin
                r_temp_hi <= i_byte;
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST_IDX)
        else $error("byte count past frame end");

    a_ok_nonzero_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.has && o_result.status == ST_OK) |-> (o_result.crc != 8'd0))
        else $error("ok status with zero CRC");

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && is_last) |=> (r_count == '0 && r_crc == 8'd0))
        else $error("state not cleared after frame end");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the scratchpad frame checker: stream driver, monitor, predictor.
`timescale 1ns / 1ps

module testbench;
    import tsc_pkg::*;

    localparam int FRAME_LEN   = FRAME_BYTES_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYC  = 8;

    // Kinds of frames the generator builds
    typedef enum int {
        FR_GOOD,
        FR_BAD_CRC,
        FR_ZERO_CRC
    } t_frame_kind;

    // One byte waiting to go onto the input stream
    typedef struct {
        logic [7:0] data;
        logic       start;
    } t_wire_byte;

    // One checked frame as the block should report it
    typedef struct {
        logic [1:0]         status;
        logic signed [15:0] temperature;
        logic [7:0]         crc;
    } t_frame_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] frame_byte
    logic [0:0]  s_axis_tuser = '0;     // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [1:0] status, [17:2] temperature, [25:18] computed_crc
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    temp_scratchpad_checker #(
        .FRAME_BYTES(FRAME_LEN)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock: 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_wire_byte    pending_bytes[$];
    t_frame_report expected_reports[$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    bit            calm = 1'b0;
    bit            aligned = 1'b1;

    // Predictor state and limit copies
    logic [3:0]         frame_pos = '0;
    logic [7:0]         crc_acc = '0;
    logic [7:0]         temp_lo = '0;
    logic [7:0]         temp_hi = '0;
    logic signed [15:0] lim_hi = UPPER_RESET;
    logic signed [15:0] lim_lo = LOWER_RESET;

    // Dallas/Maxim CRC-8, one byte, LSB first
    function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc ^ b;
        repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int expv, input int actv);
        if (mismatch_count < 10) begin
            $display("mismatch %s: expected %0d got %0d", what, expv, actv);
        end
        mismatch_count++;
    endtask

    // Advance the predictor by one accepted byte
    task automatic scratchpad_absorb(input logic [7:0] b, input logic start);
        t_frame_report      rep;
        logic signed [15:0] raw;
        if (start) begin
            frame_pos = '0;
            crc_acc   = '0;
        end
        if (frame_pos >= FRAME_LEN - 1) begin
            raw = {temp_hi, temp_lo};
            if (crc_acc != b || crc_acc == 8'h00) begin
                rep.status = ST_CRC;
            end else if (raw > lim_hi || raw < lim_lo) begin
                rep.status = ST_RANGE;
            end else begin
                rep.status = ST_OK;
            end
            rep.temperature = raw;
            rep.crc         = crc_acc;
            expected_reports.push_back(rep);
            frame_pos = '0;
            crc_acc   = '0;
        end else begin
            if (frame_pos == 0) begin
                temp_lo = b;
            end else if (frame_pos == 1) begin
                temp_hi = b;
            end
            crc_acc   = crc_fold(crc_acc, b);
            frame_pos = frame_pos + 1'b1;
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic start);
        t_wire_byte w;
        w.data  = b;
        w.start = start;
        pending_bytes.push_back(w);
    endtask

    // Build one whole frame; the zero-CRC kind picks the last data byte so the CRC folds to 0
    task automatic queue_frame(input logic signed [15:0] temp, input t_frame_kind kind,
                               input logic start_first);
        logic [7:0] bytes [FRAME_LEN];
        logic [7:0] c;
        c = '0;
        bytes[0] = temp[7:0];
        bytes[1] = temp[15:8];
        for (int i = 2; i < FRAME_LEN - 1; i++) begin
            bytes[i] = 8'($urandom);
        end
        for (int i = 0; i < FRAME_LEN - 2; i++) begin
            c = crc_fold(c, bytes[i]);
        end
        if (kind == FR_ZERO_CRC) begin
            bytes[FRAME_LEN - 2] = c;
        end
        c = crc_fold(c, bytes[FRAME_LEN - 2]);
        case (kind)
            FR_GOOD:     bytes[FRAME_LEN - 1] = c;
            FR_BAD_CRC:  bytes[FRAME_LEN - 1] = c ^ (8'h01 << $urandom_range(0, 7));
            default:     bytes[FRAME_LEN - 1] = 8'h00;
        endcase
        for (int i = 0; i < FRAME_LEN; i++) begin
            queue_byte(bytes[i], (i == 0) ? start_first : 1'b0);
        end
        aligned = 1'b1;
    endtask

    // Temperatures cluster on the limit edges and the field extremes
    function automatic logic signed [15:0] pick_temp();
        case ($urandom_range(0, 9))
            0:       return lim_hi;
            1:       return lim_hi + 16'sd1;
            2:       return lim_lo;
            3:       return lim_lo - 16'sd1;
            4:       return 16'sh7FFF;
            5:       return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly well-formed frames, with bad CRCs, early restarts and loose bytes mixed in
    task automatic queue_random(input int n);
        int base;
        int sel;
        int len;
        base = pending_bytes.size();
        while (pending_bytes.size() - base < n) begin
            sel = $urandom_range(0, 19);
            if (sel <= 13) begin
                queue_frame(pick_temp(), FR_GOOD, aligned ? ($urandom_range(0, 3) != 0) : 1'b1);
            end else if (sel <= 15) begin
                queue_frame(pick_temp(), FR_BAD_CRC, 1'b1);
            end else if (sel == 16) begin
                queue_frame(pick_temp(), FR_ZERO_CRC, aligned ? 1'($urandom) : 1'b1);
            end else if (sel == 17) begin
                len = $urandom_range(1, FRAME_LEN - 1);
                for (int i = 0; i < len; i++) begin
                    queue_byte(8'($urandom), i == 0);
                end
                aligned = 1'b0;
            end else begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    queue_byte(8'($urandom), 1'($urandom));
                end
                aligned = 1'b0;
            end
        end
    endtask

    // Wait until the stream is empty and every report is in, then let the pipeline drain
    task automatic settle();
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // APB write of one limit, then read it back
    task automatic write_limit(input logic [2:0] addr, input logic signed [15:0] val);
        logic [31:0] rd;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_UPPER) begin
            lim_hi = val;
        end else begin
            lim_lo = val;
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[15:0] != val) begin
            note_mismatch("limit readback", int'(val), int'($signed(rd[15:0])));
        end
    endtask

    // Input driver: holds an offered item until taken, idles in bursts
    int send_gap = 0;
    always @(posedge i_clk) begin
        bit offer;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                scratchpad_absorb(s_axis_tdata, s_axis_tuser[0]);
                void'(pending_bytes.pop_front());
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    offer = 1'b0;
                end else if (!calm && $urandom_range(0, 11) == 0) begin
                    send_gap = $urandom_range(0, 12);
                    offer = 1'b0;
                end else begin
                    offer = pending_bytes.size() != 0;
                end
                s_axis_tvalid <= offer;
                if (offer) begin
                    s_axis_tdata <= pending_bytes[0].data;
                    s_axis_tuser <= pending_bytes[0].start;
                end
            end
        end
    end

    // Result monitor: compares each report with the oldest expectation
    int recv_gap = 0;
    always @(posedge i_clk) begin
        t_frame_report rep;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_reports.size() == 0) begin
                    note_mismatch("unexpected report, status", -1, int'(m_axis_tdata[1:0]));
                end else begin
                    rep = expected_reports.pop_front();
                    if (m_axis_tdata[1:0] != rep.status) begin
                        note_mismatch("status", int'(rep.status), int'(m_axis_tdata[1:0]));
                    end
                    if (m_axis_tdata[17:2] != rep.temperature) begin
                        note_mismatch("temperature", int'(rep.temperature),
                                      int'($signed(m_axis_tdata[17:2])));
                    end
                    if (m_axis_tdata[25:18] != rep.crc) begin
                        note_mismatch("computed_crc", int'(rep.crc), int'(m_axis_tdata[25:18]));
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(0, 12);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Test sequence
    initial begin
        logic signed [15:0] a;
        logic signed [15:0] b;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: limit edges at reset values, missing start, early restart, zero CRC
        queue_frame(UPPER_RESET, FR_GOOD, 1'b1);
        queue_frame(LOWER_RESET - 16'sd1, FR_GOOD, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_frame(16'sh7FFF, FR_ZERO_CRC, 1'b1);
        settle();

        // Widest limits
        write_limit(ADDR_UPPER, 16'sh7FFF);
        write_limit(ADDR_LOWER, 16'sh8000);
        @(negedge i_clk);
        queue_frame(16'sh8000, FR_GOOD, 1'b1);
        queue_frame(16'sh7FFF, FR_BAD_CRC, 1'b1);
        queue_random(170);
        settle();

        // Crossed limits
        write_limit(ADDR_UPPER, -16'sd100);
        write_limit(ADDR_LOWER, 16'sd100);
        @(negedge i_clk);
        queue_random(130);
        settle();

        // Random ordered limits
        a = 16'($urandom);
        b = 16'($urandom);
        if (a < b) begin
            write_limit(ADDR_UPPER, b);
            write_limit(ADDR_LOWER, a);
        end else begin
            write_limit(ADDR_UPPER, a);
            write_limit(ADDR_LOWER, b);
        end
        @(negedge i_clk);
        queue_random(170);
        settle();

        // Single accepted value
        a = 16'($signed($urandom_range(0, 400)) - 200);
        write_limit(ADDR_UPPER, a);
        write_limit(ADDR_LOWER, a);
        @(negedge i_clk);
        queue_random(130);
        settle();

        // Back to reset values, no idling on either side
        write_limit(ADDR_UPPER, UPPER_RESET);
        write_limit(ADDR_LOWER, LOWER_RESET);
        calm = 1'b1;
        @(negedge i_clk);
        queue_random(220);
        settle();

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
